// File: sv/cwis_pkg.sv
// shared types and constants of the constant-weight index sampler
// used by every module of the sampler; no dependencies
`timescale 1ns / 1ps

package cwis_pkg;

   localparam int MAX_LENGTH     = 4096;
   localparam int MAX_WEIGHT_DEF = 64;
   localparam int LEN_W          = 13;
   localparam int POS_W          = 12;
   localparam int WORD_W         = 31;
   localparam int WGT_W          = 7;
   localparam int ADDR_W         = 3;
   localparam int DATA_W         = 32;
   localparam int DIV_CNT_W      = 5;

   // register indexes, address bit 2 selects the register
   localparam logic REG_BLOCK_LENGTH = 1'b0;
   localparam logic REG_WEIGHT       = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // one entry of the sparse permutation map: perm[key] = val
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] key;
      logic [POS_W-1:0] val;
   } map_entry_type;

   // one entry of the sorted chosen list
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] val;
   } sort_entry_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } map_ctrl_type;

   typedef struct packed {
      logic             clear;
      logic             insert;
      logic             shift;
      logic [POS_W-1:0] value;
   } sort_ctrl_type;

endpackage

// File: sv/cwis_divider.sv
// bit-serial restoring remainder unit: word mod divisor, one bit per cycle
// depends on cwis_pkg
`timescale 1ns / 1ps

module cwis_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cwis_pkg::WORD_W-1:0] word,
   input  logic [cwis_pkg::LEN_W-1:0]  divisor,
   output logic                       done,
   output logic [cwis_pkg::LEN_W-1:0]  remainder
);
   import cwis_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [LEN_W-1:0]     dvs_ff, dvs_in;
   logic [LEN_W:0]       rem_ff, rem_in;
   logic [LEN_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      word_in = word_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[LEN_W-1:0], word_ff[WORD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         word_in = word;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         word_in = {word_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      word_ff <= word_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[LEN_W-1:0];

endmodule

// File: sv/cwis_map_cell.sv
// one cell of the rotating permutation-map ring
// depends on cwis_pkg
`timescale 1ns / 1ps

module cwis_map_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cwis_pkg::map_ctrl_type  ctrl,
   input  logic                    wr_en,
   input  cwis_pkg::map_entry_type wr_entry,
   input  cwis_pkg::map_entry_type shift_in,
   output cwis_pkg::map_entry_type entry
);
   import cwis_pkg::*;

   map_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (wr_en) begin
         entry_in = wr_entry;
      end else if (ctrl.shift) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key <= entry_in.key;
      entry_ff.val <= entry_in.val;
   end

   assign entry = entry_ff;

endmodule

// File: sv/cwis_sort_cell.sv
// one cell of the insertion-sort chain, ascending from cell 0
// depends on cwis_pkg
`timescale 1ns / 1ps

module cwis_sort_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  cwis_pkg::sort_ctrl_type  ctrl,
   input  logic                     prev_keep,
   input  cwis_pkg::sort_entry_type prev_entry,
   input  cwis_pkg::sort_entry_type next_entry,
   output logic                     keep,
   output cwis_pkg::sort_entry_type entry
);
   import cwis_pkg::*;

   sort_entry_type entry_ff, entry_in;

   assign keep = entry_ff.valid && (entry_ff.val < ctrl.value);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.insert) begin
         if (!keep) begin
            // new value lands where the left neighbor still stays below it
            if (prev_keep) begin
               entry_in.valid = 1'b1;
               entry_in.val   = ctrl.value;
            end else begin
               entry_in = prev_entry;
            end
         end
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.val <= entry_in.val;
   end

   assign entry = entry_ff;

endmodule

// File: sv/constant_weight_index_sampler_core.sv
// top level of the constant-weight index sampler
// depends on cwis_pkg, cwis_divider, cwis_map_cell, cwis_sort_cell
`timescale 1ns / 1ps

// Each request is one draw of a partial Fisher-Yates shuffle. A draw runs
// the word through the bit-serial remainder unit, then rotates the
// permutation map once through its ring of cells, then inserts the chosen
// position into the sort chain; no request is taken while a draw is busy.
// The whole map is cleared at once on the last draw, so the permutation
// returns to identity with no clearing pass. On the weight-th draw the
// chosen positions leave the sort chain in ascending order, one per cycle
// unless rsp_stall holds them, and no request is taken until the last is gone.
module constant_weight_index_sampler_core #(
   parameter int MAX_WEIGHT = cwis_pkg::MAX_WEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cwis_pkg::WORD_W-1:0] req_random_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cwis_pkg::POS_W-1:0]  rsp_position,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cwis_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [cwis_pkg::DATA_W-1:0] csr_pwdata,
   output logic [cwis_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import cwis_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WEIGHT + 1);
   localparam int STEP_W = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

   logic [LEN_W-1:0] block_length_ff, block_length_in;
   logic [WGT_W-1:0] weight_ff, weight_in;
   logic             cfg_wr;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] draw_ff, draw_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] slot_ff, slot_in;
   logic             slot_found_ff, slot_found_in;
   logic             got_i_ff, got_i_in;
   logic             got_j_ff, got_j_in;
   logic [POS_W-1:0] pi_ff, pi_in;
   logic [POS_W-1:0] pj_ff, pj_in;
   logic [POS_W-1:0] j_ff, j_in;

   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] eff_wgt;
   logic [LEN_W-1:0] wgt_tmp;
   logic [POS_W-1:0] idx_i;
   logic [LEN_W-1:0] divisor;
   logic             div_done;
   logic [LEN_W-1:0] div_rem;
   logic             req_acc;
   logic             rsp_acc;

   map_ctrl_type     map_ctrl;
   map_entry_type    map_q [MAX_WEIGHT];
   map_entry_type    head_mod;
   map_entry_type    new_entry;
   logic             map_wr;
   logic             match_i, match_j;

   sort_ctrl_type    sort_ctrl;
   sort_entry_type   sort_q [MAX_WEIGHT];
   logic             sort_keep [MAX_WEIGHT];

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      block_length_in = block_length_ff;
      weight_in       = weight_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_BLOCK_LENGTH: block_length_in = csr_pwdata[LEN_W-1:0];
            REG_WEIGHT:       weight_in       = csr_pwdata[WGT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BLOCK_LENGTH: csr_prdata = {{(DATA_W-LEN_W){1'b0}}, block_length_ff};
         REG_WEIGHT:       csr_prdata = {{(DATA_W-WGT_W){1'b0}}, weight_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // effective length and weight
   always_comb begin
      eff_len = block_length_ff;
      if (block_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (block_length_ff > LEN_W'(MAX_LENGTH)) begin
         eff_len = LEN_W'(MAX_LENGTH);
      end
      wgt_tmp = {{(LEN_W-WGT_W){1'b0}}, weight_ff};
      if (wgt_tmp == '0) begin
         wgt_tmp = LEN_W'(1);
      end
      if (wgt_tmp > LEN_W'(MAX_WEIGHT)) begin
         wgt_tmp = LEN_W'(MAX_WEIGHT);
      end
      eff_wgt = (wgt_tmp > eff_len) ? eff_len : wgt_tmp;
   end

   assign idx_i   = {{(POS_W-CNT_W){1'b0}}, draw_ff};
   assign divisor = eff_len - {1'b0, idx_i};

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   cwis_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (req_acc),
      .word      (req_random_word),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // head of the map ring during a scan
   assign match_i = map_q[0].valid && (map_q[0].key == idx_i);
   assign match_j = map_q[0].valid && (map_q[0].key == j_ff);

   always_comb begin
      head_mod = map_q[0];
      if (match_i || match_j) begin
         head_mod.valid = 1'b0;
      end
      new_entry.valid = 1'b1;
      new_entry.key   = j_ff;
      new_entry.val   = got_i_ff ? pi_ff : idx_i;
   end

   // result side
   assign rsp_valid    = (state_ff == ST_EMIT) && sort_q[0].valid;
   assign rsp_position = sort_q[0].val;
   assign rsp_acc      = rsp_valid && !rsp_stall;
   generate
      if (MAX_WEIGHT > 1) begin : g_last
         assign rsp_last = !sort_q[1].valid;
      end else begin : g_last1
         assign rsp_last = 1'b1;
      end
   endgenerate

   // sequencer
   always_comb begin
      state_in      = state_ff;
      draw_in       = draw_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      slot_found_in = slot_found_ff;
      got_i_in      = got_i_ff;
      got_j_in      = got_j_ff;
      pi_in         = pi_ff;
      pj_in         = pj_ff;
      j_in          = j_ff;
      map_ctrl      = '0;
      map_wr        = 1'b0;
      sort_ctrl     = '0;
      sort_ctrl.value = got_j_ff ? pj_ff : j_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               j_in          = idx_i + div_rem[POS_W-1:0];
               step_in       = '0;
               slot_found_in = 1'b0;
               got_i_in      = 1'b0;
               got_j_in      = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            map_ctrl.shift = 1'b1;
            if (match_i) begin
               got_i_in = 1'b1;
               pi_in    = map_q[0].val;
            end
            if (match_j) begin
               got_j_in = 1'b1;
               pj_in    = map_q[0].val;
            end
            // remember the first cell that is free after this pass
            if (!slot_found_ff && (!map_q[0].valid || match_i || match_j)) begin
               slot_found_in = 1'b1;
               slot_in       = step_ff;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAX_WEIGHT - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            sort_ctrl.insert = 1'b1;
            draw_in = draw_ff + 1'b1;
            if ({{(LEN_W-CNT_W){1'b0}}, draw_ff} + LEN_W'(1) == eff_wgt) begin
               map_ctrl.clear = 1'b1;
               draw_in        = '0;
               state_in       = ST_EMIT;
            end else begin
               map_wr   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               sort_ctrl.shift = 1'b1;
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a register write restarts the vector
      if (cfg_wr) begin
         state_in        = ST_IDLE;
         draw_in         = '0;
         map_ctrl        = '0;
         map_ctrl.clear  = 1'b1;
         map_wr          = 1'b0;
         sort_ctrl       = '0;
         sort_ctrl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= LEN_W'(MAX_LENGTH);
         weight_ff       <= WGT_W'(MAX_WEIGHT_DEF);
         state_ff        <= ST_IDLE;
         draw_ff         <= '0;
      end else begin
         block_length_ff <= block_length_in;
         weight_ff       <= weight_in;
         state_ff        <= state_in;
         draw_ff         <= draw_in;
      end
      step_ff       <= step_in;
      slot_ff       <= slot_in;
      slot_found_ff <= slot_found_in;
      got_i_ff      <= got_i_in;
      got_j_ff      <= got_j_in;
      pi_ff         <= pi_in;
      pj_ff         <= pj_in;
      j_ff          <= j_in;
   end

   // map ring: cell k takes from cell k+1, the last cell takes the edited head
   generate
      for (genvar k = 0; k < MAX_WEIGHT; k++) begin : g_map
         map_entry_type ring_in;
         if (k == MAX_WEIGHT - 1) begin : g_tail
            assign ring_in = head_mod;
         end else begin : g_body
            assign ring_in = map_q[k+1];
         end
         cwis_map_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (map_ctrl),
            .wr_en    (map_wr && (slot_ff == STEP_W'(k))),
            .wr_entry (new_entry),
            .shift_in (ring_in),
            .entry    (map_q[k])
         );
      end
   endgenerate

   // sort chain
   generate
      for (genvar k = 0; k < MAX_WEIGHT; k++) begin : g_sort
         logic           p_keep;
         sort_entry_type p_entry;
         sort_entry_type n_entry;
         if (k == 0) begin : g_first
            assign p_keep  = 1'b1;
            assign p_entry = '0;
         end else begin : g_mid
            assign p_keep  = sort_keep[k-1];
            assign p_entry = sort_q[k-1];
         end
         if (k == MAX_WEIGHT - 1) begin : g_end
            assign n_entry = '0;
         end else begin : g_nxt
            assign n_entry = sort_q[k+1];
         end
         cwis_sort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (sort_ctrl),
            .prev_keep  (p_keep),
            .prev_entry (p_entry),
            .next_entry (n_entry),
            .keep       (sort_keep[k]),
            .entry      (sort_q[k])
         );
      end
   endgenerate

endmodule
